// ----- rtl/tpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared widths, codes and control bundles of the two-key priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int CMD_W  = 2;
  localparam int TAG_W  = 16;
  localparam int RANK_W = 8;
  localparam int DUR_W  = 16;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
    logic [DUR_W-1:0]  dur;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    insert;
    logic    pop;
    logic    clear;
    status_e status;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ----- rtl/tpq_cmd_if.sv -----
// ----------------------------------------------------------------------------
// tpq_cmd_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface tpq_cmd_if;
  import tpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TAG_W-1:0]  entry_tag;
  logic [RANK_W-1:0] rank;
  logic [DUR_W-1:0]  duration;

  modport source (output valid, command, entry_tag, rank, duration, input ready);
  modport sink   (input valid, command, entry_tag, rank, duration, output ready);
endinterface

// ----- rtl/tpq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tpq_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface tpq_rsp_if;
  import tpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  out_tag;
  logic [RANK_W-1:0] out_rank;
  logic [DUR_W-1:0]  out_duration;
  logic              out_valid;
  logic [STAT_W-1:0] status;
  logic [FILL_W-1:0] fill;

  modport source (output valid, out_tag, out_rank, out_duration, out_valid, status, fill,
                  input ready);
  modport sink   (input valid, out_tag, out_rank, out_duration, out_valid, status, fill,
                  output ready);
endinterface

// ----- rtl/tpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpq_ctrl
// Handshake state machine and command decode for the priority queue.
// ----------------------------------------------------------------------------
module tpq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  logic [tpq_pkg::CMD_W-1:0] cmd_command_i,
  output logic                  cmd_ready_o,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  input  tpq_pkg::dp_stat_t     stat_i,
  output tpq_pkg::dp_ctl_t      ctl_o
);
  import tpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // the result register frees up in the same cycle it is drained
  assign rsp_valid_o = (state_q == S_HOLD);
  assign cmd_ready_o = (state_q == S_IDLE) || rsp_ready_i;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_HOLD;
      S_HOLD: if (rsp_ready_i && !accept) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl_o        = '0;
    ctl_o.status = ST_OK;
    ctl_o.load   = accept;
    if (accept) begin
      unique case (cmd_command_i)
        CMD_INSERT: begin
          if (stat_i.full) ctl_o.status = ST_FULL;
          else             ctl_o.insert = 1'b1;
        end
        CMD_POP: begin
          if (stat_i.empty) ctl_o.status = ST_EMPTY;
          else              ctl_o.pop    = 1'b1;
        end
        CMD_CLEAR: ctl_o.clear = 1'b1;
        default: ;
      endcase
    end
  end

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.insert, ctl_o.pop, ctl_o.clear}))
    else $error("more than one queue operation issued");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.insert |-> !stat_i.full)
    else $error("insert issued on full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.pop |-> !stat_i.empty)
    else $error("pop issued on empty queue");

endmodule

// ----- rtl/tpq_datapath.sv -----
// ----------------------------------------------------------------------------
// tpq_datapath
// Sorted shift-register slots with per-slot compare, occupancy count and
// result register.
// ----------------------------------------------------------------------------
module tpq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tpq_pkg::TAG_W-1:0]  entry_tag_i,
  input  logic [tpq_pkg::RANK_W-1:0] rank_i,
  input  logic [tpq_pkg::DUR_W-1:0]  duration_i,
  input  tpq_pkg::dp_ctl_t           ctl_i,
  output tpq_pkg::dp_stat_t          stat_o,
  output logic [tpq_pkg::TAG_W-1:0]  out_tag_o,
  output logic [tpq_pkg::RANK_W-1:0] out_rank_o,
  output logic [tpq_pkg::DUR_W-1:0]  out_duration_o,
  output logic                       out_valid_o,
  output logic [tpq_pkg::STAT_W-1:0] status_o,
  output logic [tpq_pkg::FILL_W-1:0] fill_o
);
  import tpq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  slot_t              slot_q [DEPTH];
  slot_t              prev_s [DEPTH];
  slot_t              next_s [DEPTH];
  slot_t              new_s;
  logic [DEPTH-1:0]   in_front;
  logic [DEPTH-1:0]   take_new;
  logic [OCC_W-1:0]   occ_q, occ_d;

  slot_t              rsp_slot_q;
  logic               rsp_hit_q;
  status_e            rsp_status_q;
  logic [FILL_W-1:0]  rsp_fill_q;

  assign new_s = '{tag: entry_tag_i, rank: rank_i, dur: duration_i};

  // Slots past the fill count read as "larger", so the first free slot
  // catches the new word when nothing stored outranks it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign in_front[i] = (OCC_W'(i) >= occ_q) ||
                         (slot_q[i].rank > rank_i) ||
                         ((slot_q[i].rank == rank_i) && (slot_q[i].dur > duration_i));

    if (i == 0) begin : g_head
      assign take_new[i] = in_front[i];
      assign prev_s[i]   = new_s;
    end else begin : g_body
      assign take_new[i] = in_front[i] && !in_front[i-1];
      assign prev_s[i]   = slot_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_s[i] = slot_q[i];
    end else begin : g_link
      assign next_s[i] = slot_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.insert && in_front[i]) begin
        slot_q[i] <= take_new[i] ? new_s : prev_s[i];
      end else if (ctl_i.pop) begin
        slot_q[i] <= next_s[i];
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    priority if (ctl_i.insert) occ_d = occ_q + OCC_W'(1);
    else if (ctl_i.pop)        occ_d = occ_q - OCC_W'(1);
    else if (ctl_i.clear)      occ_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rsp_slot_q   <= ctl_i.pop ? slot_q[0] : '0;
      rsp_hit_q    <= ctl_i.pop;
      rsp_status_q <= ctl_i.status;
      rsp_fill_q   <= FILL_W'(occ_d);
    end
  end

  assign stat_o.full  = (occ_q == OCC_W'(DEPTH));
  assign stat_o.empty = (occ_q == '0);

  assign out_tag_o      = rsp_slot_q.tag;
  assign out_rank_o     = rsp_slot_q.rank;
  assign out_duration_o = rsp_slot_q.dur;
  assign out_valid_o    = rsp_hit_q;
  assign status_o       = rsp_status_q;
  assign fill_o         = rsp_fill_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.insert |=> occ_q == $past(occ_q) + OCC_W'(1))
    else $error("insert did not grow occupancy");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |=> occ_q == $past(occ_q) - OCC_W'(1))
    else $error("pop did not shrink occupancy");

endmodule

// ----- rtl/two_key_stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// two_key_stable_priority_queue
// Bounded sorted queue keyed on (rank, duration), stable for equal keys.
//
//   channel  dir  handshake      word
//   cmd_i    in   valid/ready    command, entry_tag, rank, duration
//   rsp_o    out  valid/ready    out_tag, out_rank, out_duration, out_valid,
//                                status, fill
//
// One command per cycle while results are taken: every slot compares against the new
// key in parallel and the slot row shifts in the same cycle; the result is captured
// in an output register when the command is taken.
// A new command is taken while the previous result is drained in the same cycle.
// A stalled result holds cmd_i.ready low until it is taken.
// Reset empties the queue at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
module two_key_stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpq_cmd_if.sink   cmd_i,
  tpq_rsp_if.source rsp_o
);
  import tpq_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  tpq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_i.valid),
    .cmd_command_i (cmd_i.command),
    .cmd_ready_o   (cmd_i.ready),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .stat_i        (stat),
    .ctl_o         (ctl)
  );

  tpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_tag_i    (cmd_i.entry_tag),
    .rank_i         (cmd_i.rank),
    .duration_i     (cmd_i.duration),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .out_tag_o      (rsp_o.out_tag),
    .out_rank_o     (rsp_o.out_rank),
    .out_duration_o (rsp_o.out_duration),
    .out_valid_o    (rsp_o.out_valid),
    .status_o       (rsp_o.status),
    .fill_o         (rsp_o.fill)
  );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-key stable priority queue. Commands go in
// on the cmd channel and each response word is checked against a sorted-array
// predictor kept in the bench. The run covers empty pops, clear, the unused
// command code, ties on both keys, insert on a full queue, and long random
// fill/drain traffic with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import tpq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
    logic [DUR_W-1:0]  dur;
    logic              valid;
    status_e           status;
    logic [FILL_W-1:0] fill;
  } rsp_word_t;

  logic clk_i;
  logic rst_ni;

  tpq_cmd_if cmd_bus ();
  tpq_rsp_if rsp_bus ();

  two_key_stable_priority_queue #(.DEPTH(DEPTH)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .rsp_o (rsp_bus)
  );

  // queue contents as the bench sees them, head at index 0
  slot_t     sorted_slots[DEPTH];
  int        held_count;
  rsp_word_t expected_rsp[$];
  rsp_word_t head_rsp;

  bit idle_on;
  int errors;
  int n_insert, n_full, n_pop, n_empty, n_clear, n_unused, peak_fill;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Applies one command to the sorted array, returns the response word.
  function automatic rsp_word_t queue_step(input logic [CMD_W-1:0] code,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [RANK_W-1:0] rank,
                                           input logic [DUR_W-1:0] dur);
    rsp_word_t res;
    int pos;
    res = '{tag: '0, rank: '0, dur: '0, valid: 1'b0, status: ST_OK, fill: '0};
    case (code)
      CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          // first stored entry with a strictly larger key takes the new one in front
          pos = 0;
          while (pos < held_count &&
                 !(sorted_slots[pos].rank > rank ||
                   (sorted_slots[pos].rank == rank && sorted_slots[pos].dur > dur)))
            pos++;
          for (int k = held_count; k > pos; k--) sorted_slots[k] = sorted_slots[k-1];
          sorted_slots[pos] = '{tag: tag, rank: rank, dur: dur};
          held_count++;
          n_insert++;
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          res.tag   = sorted_slots[0].tag;
          res.rank  = sorted_slots[0].rank;
          res.dur   = sorted_slots[0].dur;
          res.valid = 1'b1;
          for (int k = 1; k < held_count; k++) sorted_slots[k-1] = sorted_slots[k];
          held_count--;
          n_pop++;
        end
      end
      CMD_CLEAR: begin
        held_count = 0;
        n_clear++;
      end
      default: n_unused++;
    endcase
    if (held_count > peak_fill) peak_fill = held_count;
    res.fill = FILL_W'(held_count);
    return res;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] code, input logic [TAG_W-1:0] tag,
                           input logic [RANK_W-1:0] rank, input logic [DUR_W-1:0] dur);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.command   <= code;
    cmd_bus.entry_tag <= tag;
    cmd_bus.rank      <= rank;
    cmd_bus.duration  <= dur;
    do @(posedge clk_i); while (!cmd_bus.ready);
    expected_rsp.push_back(queue_step(code, tag, rank, dur));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("response word with none expected: tag %0h status %0d",
               rsp_bus.out_tag, rsp_bus.status);
        errors++;
      end else begin
        head_rsp = expected_rsp.pop_front();
        check_field("out_tag",      head_rsp.tag,    rsp_bus.out_tag);
        check_field("out_rank",     head_rsp.rank,   rsp_bus.out_rank);
        check_field("out_duration", head_rsp.dur,    rsp_bus.out_duration);
        check_field("out_valid",    head_rsp.valid,  rsp_bus.out_valid);
        check_field("status",       head_rsp.status, rsp_bus.status);
        check_field("fill",         head_rsp.fill,   rsp_bus.fill);
      end
    end
  end

  // response backpressure: stall bursts alternating with open stretches
  initial begin
    rsp_bus.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic test_empty_queue;
    send_word(CMD_POP,    16'hFFFF, 8'hFF, 16'hFFFF);
    send_word(CMD_CLEAR,  16'h0000, 8'h00, 16'h0000);
    send_word(CMD_UNUSED, 16'hA5A5, 8'h5A, 16'h5A5A);
  endtask

  // fill to the top with extreme keys and ties, overflow, pop a few, clear
  task automatic test_fill_to_full;
    slot_t seed_list[10] = '{
      '{tag: 16'h0001, rank: 8'h80, dur: 16'h0100},
      '{tag: 16'h0002, rank: 8'h80, dur: 16'h0100},
      '{tag: 16'h0003, rank: 8'h80, dur: 16'h0050},
      '{tag: 16'h0004, rank: 8'hFF, dur: 16'hFFFF},
      '{tag: 16'h0005, rank: 8'h00, dur: 16'h0000},
      '{tag: 16'h0006, rank: 8'h00, dur: 16'h0000},
      '{tag: 16'h0007, rank: 8'hFF, dur: 16'hFFFF},
      '{tag: 16'hFFFF, rank: 8'h80, dur: 16'h0100},
      '{tag: 16'h0000, rank: 8'h01, dur: 16'hFFFF},
      '{tag: 16'h8000, rank: 8'hFE, dur: 16'h0000}
    };
    foreach (seed_list[i])
      send_word(CMD_INSERT, seed_list[i].tag, seed_list[i].rank, seed_list[i].dur);
    for (int i = 0; i < DEPTH - 10; i++)
      send_word(CMD_INSERT, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)));
    send_word(CMD_INSERT, 16'h1234, 8'h00, 16'h0000);
    repeat (3) send_word(CMD_POP, 16'h0000, 8'h00, 16'h0000);
    send_word(CMD_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  // Segments biased toward filling, draining or a mix. Keys mostly from a
  // narrow set so equal-rank and equal-key ties are common.
  task automatic random_traffic(input int n_words, input bit with_idle);
    int done;
    int seg_len;
    int ins_pct;
    int r;
    logic [CMD_W-1:0] code;
    logic [RANK_W-1:0] rank;
    logic [DUR_W-1:0] dur;
    done = 0;
    while (done < n_words) begin
      seg_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 20;
        default: ins_pct = 55;
      endcase
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < seg_len && done < n_words; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2)                         code = CMD_CLEAR;
        else if (r < 4)                    code = CMD_UNUSED;
        else if (r - 4 < ins_pct * 96 / 100) code = CMD_INSERT;
        else                               code = CMD_POP;
        if ($urandom_range(0, 9) < 7) begin
          rank = 8'($urandom_range(0, 3));
          dur  = 16'($urandom_range(0, 3));
        end else begin
          rank = 8'($urandom_range(0, 255));
          dur  = 16'($urandom_range(0, 65535));
        end
        send_word(code, 16'($urandom_range(0, 65535)), rank, dur);
        done++;
      end
    end
  endtask

  task automatic test_random_mix;
    random_traffic(600, 1'b1);
  endtask

  task automatic test_back_to_back;
    random_traffic(50, 1'b0);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.command   <= CMD_INSERT;
    cmd_bus.entry_tag <= '0;
    cmd_bus.rank      <= '0;
    cmd_bus.duration  <= '0;
    idle_on    = 1'b1;
    errors     = 0;
    held_count = 0;
    n_insert = 0; n_full = 0; n_pop = 0; n_empty = 0;
    n_clear = 0; n_unused = 0; peak_fill = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_random_mix();
    test_back_to_back();

    cmd_bus.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("covered %0d inserts, %0d dropped on full, %0d pops, %0d pops on empty",
             n_insert, n_full, n_pop, n_empty);
    $display("covered %0d clears, %0d unused codes, deepest fill %0d of %0d",
             n_clear, n_unused, peak_fill, DEPTH);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
